// ===== sv/mcrx_pkg.sv =====
// package for the multi-channel overwriting receive fifo
// item types, operation codes, controller state type and address helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mcrx_pkg;

   // sizing
   localparam int CHANNELS   = 4;
   localparam int FIFO_DEPTH = 16;
   localparam int MASK_W     = 4;
   localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int MEM_DEPTH  = CHANNELS * FIFO_DEPTH;
   localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   // operation codes
   localparam logic [1:0] OP_RECEIVE = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_TX_REQ  = 2'd2;
   localparam logic [1:0] OP_TX_DONE = 2'd3;

   typedef struct packed {
      logic [1:0] operation;
      logic [1:0] channel;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [1:0] out_channel;
      logic [7:0] out_data;
      logic       read_valid;
      logic       forwarded;
      logic       dropped_oldest;
      logic       tx_go;
      logic       tx_refused;
      logic [4:0] fill_count;
      logic       busy_res;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_full;
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // channel field in range of the configured channel count
   function automatic logic chan_ok(input logic [1:0] ch);
      return 32'(ch) < CHANNELS;
   endfunction

   // flat memory address of a slot within a channel ring
   function automatic logic [ADDR_W-1:0] mem_addr(input logic [CH_IDX_W-1:0] ci,
                                                  input logic [POS_W-1:0] pos);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(ADDR_W'(ci) * ADDR_W'(FIFO_DEPTH));
      return ADDR_W'(base + ADDR_W'(pos));
   endfunction

   // ring position plus one, wrapped
   function automatic logic [POS_W-1:0] pos_next(input logic [POS_W-1:0] pos);
      return (32'(pos) == FIFO_DEPTH - 1) ? '0 : POS_W'(pos + 1'b1);
   endfunction

endpackage

`default_nettype wire

// ===== sv/mcrx_ctrl.sv =====
// controller state machine for the multi-channel receive fifo
// sequences accept and execute steps; uses mcrx_pkg types
`timescale 1ns / 1ps
`default_nettype none

module mcrx_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire                        rsp_stall,
   input  wire mcrx_pkg::status_type  status,
   output mcrx_pkg::cmd_type          cmd
);

   mcrx_pkg::state_type state_ff, state_in;
   logic                out_free;

   // result register can take a new item this cycle
   assign out_free = !status.rsp_full || !rsp_stall;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcrx_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      req_stall  = 1'b1;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         mcrx_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = mcrx_pkg::ST_EXEC;
            end
         end
         mcrx_pkg::ST_EXEC: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = mcrx_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcrx_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/mcrx_datapath.sv =====
// datapath for the multi-channel receive fifo: byte memory, ring pointers,
// busy flags, bypass register and result register; uses mcrx_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcrx_datapath (
   input  wire                               clock,
   input  wire                               reset,
   input  wire mcrx_pkg::req_type            req_data,
   output mcrx_pkg::rsp_type                 rsp_data,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   input  wire                               csr_wr_en,
   input  wire [mcrx_pkg::MASK_W-1:0]        csr_wr_data,
   input  wire mcrx_pkg::cmd_type            cmd,
   output mcrx_pkg::status_type              status
);

   // byte memory
   logic [7:0] mem [mcrx_pkg::MEM_DEPTH];
   logic [7:0] rd_data_ff;

   // per channel state
   logic [mcrx_pkg::POS_W-1:0] head_ff [mcrx_pkg::CHANNELS];
   logic [mcrx_pkg::CNT_W-1:0] cnt_ff  [mcrx_pkg::CHANNELS];
   logic [mcrx_pkg::CHANNELS-1:0] busy_ff;
   logic [mcrx_pkg::MASK_W-1:0]   bypass_ff;

   mcrx_pkg::req_type item_ff;
   mcrx_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff;

   logic [mcrx_pkg::CH_IDX_W-1:0] req_ci, ci;
   logic [mcrx_pkg::ADDR_W-1:0]   rd_addr, wr_addr;
   logic                          ch_ok;
   logic [mcrx_pkg::POS_W-1:0]    head_cur, head_in, tail_pos;
   logic [mcrx_pkg::CNT_W-1:0]    cnt_cur, cnt_in;
   logic [mcrx_pkg::POS_W:0]      tail_sum;
   logic                          busy_cur, busy_in, mem_we;

   // read address from the incoming item, oldest slot of its channel
   assign req_ci  = mcrx_pkg::chan_ok(req_data.channel)
                    ? mcrx_pkg::CH_IDX_W'(req_data.channel) : '0;
   assign rd_addr = mcrx_pkg::mem_addr(req_ci, head_ff[req_ci]);

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= item_ff.data;
      end
      if (cmd.load) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // held item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
   end

   // current channel view
   assign ch_ok    = mcrx_pkg::chan_ok(item_ff.channel);
   assign ci       = ch_ok ? mcrx_pkg::CH_IDX_W'(item_ff.channel) : '0;
   assign head_cur = head_ff[ci];
   assign cnt_cur  = cnt_ff[ci];
   assign busy_cur = busy_ff[ci];

   // append position, head plus count wrapped once
   assign tail_sum = (mcrx_pkg::POS_W + 1)'(head_cur)
                     + (mcrx_pkg::POS_W + 1)'(cnt_cur);
   assign tail_pos = (32'(tail_sum) >= mcrx_pkg::FIFO_DEPTH)
                     ? mcrx_pkg::POS_W'(32'(tail_sum) - mcrx_pkg::FIFO_DEPTH)
                     : mcrx_pkg::POS_W'(tail_sum);

   // execute the held item
   always_comb begin
      rsp_in             = '0;
      rsp_in.out_channel = item_ff.channel;
      head_in            = head_cur;
      cnt_in             = cnt_cur;
      busy_in            = busy_cur;
      mem_we             = 1'b0;
      wr_addr            = mcrx_pkg::mem_addr(ci, tail_pos);
      if (ch_ok) begin
         unique case (item_ff.operation)
            mcrx_pkg::OP_RECEIVE: begin
               if (bypass_ff[item_ff.channel]) begin
                  rsp_in.forwarded = 1'b1;
                  rsp_in.out_data  = item_ff.data;
               end else if (32'(cnt_cur) >= mcrx_pkg::FIFO_DEPTH) begin
                  // full ring: overwrite oldest and advance head
                  wr_addr               = mcrx_pkg::mem_addr(ci, head_cur);
                  mem_we                = cmd.commit;
                  head_in               = mcrx_pkg::pos_next(head_cur);
                  rsp_in.dropped_oldest = 1'b1;
               end else begin
                  mem_we = cmd.commit;
                  cnt_in = mcrx_pkg::CNT_W'(cnt_cur + 1'b1);
               end
            end
            mcrx_pkg::OP_READ: begin
               if (cnt_cur != '0) begin
                  rsp_in.out_data   = rd_data_ff;
                  rsp_in.read_valid = 1'b1;
                  head_in           = mcrx_pkg::pos_next(head_cur);
                  cnt_in            = mcrx_pkg::CNT_W'(cnt_cur - 1'b1);
               end
            end
            mcrx_pkg::OP_TX_REQ: begin
               if (busy_cur) begin
                  rsp_in.tx_refused = 1'b1;
               end else begin
                  busy_in         = 1'b1;
                  rsp_in.tx_go    = 1'b1;
                  rsp_in.out_data = item_ff.data;
               end
            end
            mcrx_pkg::OP_TX_DONE: begin
               busy_in = 1'b0;
            end
            default: begin
               busy_in = busy_cur;
            end
         endcase
         rsp_in.fill_count = 5'(cnt_in);
         rsp_in.busy_res   = busy_in;
      end
   end

   // channel state and bypass register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mcrx_pkg::CHANNELS; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
         busy_ff   <= '0;
         bypass_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            bypass_ff <= csr_wr_data;
         end
         if (cmd.commit && ch_ok) begin
            head_ff[ci] <= head_in;
            cnt_ff[ci]  <= cnt_in;
            busy_ff[ci] <= busy_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data        = rsp_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign status.rsp_full = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== sv/multi_channel_rx_fifo_overwrite.sv =====
// top level of the multi-channel overwriting receive fifo
// joins mcrx_ctrl and mcrx_datapath; uses mcrx_pkg
//
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid/req_stall  | req_data (operation, channel, data)
//   rsp_     | out       | rsp_valid/rsp_stall  | rsp_data (result fields)
//   csr_     | in        | csr_wr_en            | csr_wr_data (bypass mask)
//
// each item passes through an accept step that reads the oldest byte of its
// channel from the byte memory, then an execute step that updates the ring
// and loads the result register. reset clears pointers, counts, busy flags
// and bypass mask at once; the byte memory needs no clearing pass.
// a stalled result holds the execute step until the result register drains.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_rx_fifo_overwrite (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire mcrx_pkg::req_type      req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output mcrx_pkg::rsp_type           rsp_data,
   input  wire                         csr_wr_en,
   input  wire [mcrx_pkg::MASK_W-1:0]  csr_wr_data
);

   mcrx_pkg::cmd_type    cmd;
   mcrx_pkg::status_type status;

   // sequencer
   mcrx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and result logic
   mcrx_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

`default_nettype wire
